// File: rtl/core/rfp_pkg.sv
// ---------------------------------------------------------------------------
// rfp_pkg: shared types and constants for the radar frame parser
// Status, kind and type codes, register indexes, reset values and the
// result record passed between the parser and the result register.
// ---------------------------------------------------------------------------
package rfp_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int HEADER_BYTES    = 8;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LIMIT = 1'b1;

   localparam logic [7:0] START_BYTE_RESET    = 8'h01;
   localparam logic [6:0] PAYLOAD_LIMIT_RESET = 7'd64;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_HDR_BAD  = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
   localparam logic [2:0] STATUS_DATA_BAD = 3'd3;
   localparam logic [2:0] STATUS_ABORT    = 3'd4;

   localparam logic [2:0] KIND_BREATH   = 3'd0;
   localparam logic [2:0] KIND_HEART    = 3'd1;
   localparam logic [2:0] KIND_DISTANCE = 3'd2;
   localparam logic [2:0] KIND_HUMAN    = 3'd3;
   localparam logic [2:0] KIND_PHASE    = 3'd4;
   localparam logic [2:0] KIND_OTHER    = 3'd5;
   localparam logic [2:0] KIND_SHORT    = 3'd6;

   localparam logic [15:0] CODE_PHASE    = 16'h0A13;
   localparam logic [15:0] CODE_BREATH   = 16'h0A14;
   localparam logic [15:0] CODE_HEART    = 16'h0A15;
   localparam logic [15:0] CODE_DISTANCE = 16'h0A16;
   localparam logic [15:0] CODE_HUMAN    = 16'h0F09;

   localparam logic [15:0] MIN_LEN_BREATH   = 16'd4;
   localparam logic [15:0] MIN_LEN_HEART    = 16'd4;
   localparam logic [15:0] MIN_LEN_DISTANCE = 16'd8;
   localparam logic [15:0] MIN_LEN_HUMAN    = 16'd1;
   localparam logic [15:0] MIN_LEN_PHASE    = 16'd12;

   localparam logic [31:0] DISTANCE_VALID_WORD = 32'h0000_0001;

   typedef enum logic [3:0] {
      STAGE_HUNT    = 4'b0001,
      STAGE_HEADER  = 4'b0010,
      STAGE_PAYLOAD = 4'b0100,
      STAGE_CHECK   = 4'b1000
   } stage_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] seq_number;
      logic [15:0] frame_kind_code;
      logic [15:0] payload_length;
      logic [2:0]  kind;
      logic        flag_bit;
      logic [63:0] payload_head;
   } result_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       flag_bit;
   } class_type;

endpackage

// File: rtl/core/rfp_classify.sv
// ---------------------------------------------------------------------------
// rfp_classify: frame kind decode
// Maps type code and length of a good frame to its kind and the
// distance-valid or human-present flag.
// ---------------------------------------------------------------------------
module rfp_classify (
   input  logic [15:0]          type_code,
   input  logic [15:0]          length,
   input  logic [63:0]          head,
   output rfp_pkg::class_type   cls
);

   logic [31:0] word0;
   logic [31:0] word1;
   logic        float_pos;

   assign word0 = head[31:0];
   assign word1 = head[63:32];

   // positive: sign clear, not zero, not NaN
   assign float_pos = !word1[31] && (word1[30:0] != 31'd0) &&
                      !((word1[30:23] == 8'hFF) && (word1[22:0] != 23'd0));

   always_comb begin
      cls.kind     = rfp_pkg::KIND_OTHER;
      cls.flag_bit = 1'b0;
      case (type_code)
         rfp_pkg::CODE_BREATH: begin
            cls.kind = (length >= rfp_pkg::MIN_LEN_BREATH) ?
                       rfp_pkg::KIND_BREATH : rfp_pkg::KIND_SHORT;
         end
         rfp_pkg::CODE_HEART: begin
            cls.kind = (length >= rfp_pkg::MIN_LEN_HEART) ?
                       rfp_pkg::KIND_HEART : rfp_pkg::KIND_SHORT;
         end
         rfp_pkg::CODE_DISTANCE: begin
            if (length >= rfp_pkg::MIN_LEN_DISTANCE) begin
               cls.kind     = rfp_pkg::KIND_DISTANCE;
               cls.flag_bit = (word0 == rfp_pkg::DISTANCE_VALID_WORD) && float_pos;
            end else begin
               cls.kind = rfp_pkg::KIND_SHORT;
            end
         end
         rfp_pkg::CODE_HUMAN: begin
            if (length >= rfp_pkg::MIN_LEN_HUMAN) begin
               cls.kind     = rfp_pkg::KIND_HUMAN;
               cls.flag_bit = (head[7:0] != 8'd0);
            end else begin
               cls.kind = rfp_pkg::KIND_SHORT;
            end
         end
         rfp_pkg::CODE_PHASE: begin
            cls.kind = (length >= rfp_pkg::MIN_LEN_PHASE) ?
                       rfp_pkg::KIND_PHASE : rfp_pkg::KIND_SHORT;
         end
         default: begin
            cls.kind     = rfp_pkg::KIND_OTHER;
            cls.flag_bit = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/core/rfp_parser.sv
// ---------------------------------------------------------------------------
// rfp_parser: frame state machine and field capture
// Steps one transfer per cycle when fire is high through hunt, header, payload
// and checksum, and forms the result record in the cycle of the closing transfer.
// ---------------------------------------------------------------------------
module rfp_parser #(
   parameter int MAX_LEN = rfp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 cmd,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           start_byte,
   input  logic [6:0]           payload_limit,
   output logic                 res_valid,
   output rfp_pkg::result_type  res
);

   localparam int POS_W = $clog2(MAX_LEN + 1);

   rfp_pkg::stage_type stage_ff, stage_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         hxor_ff, hxor_in;
   logic [7:0]         dxor_ff, dxor_in;
   logic [15:0]        seq_ff, seq_in;
   logic [15:0]        len_ff, len_in;
   logic [15:0]        type_ff, type_in;
   logic [63:0]        head_ff, head_in;

   logic [POS_W:0]     pos_inc;
   logic [15:0]        lim;
   rfp_pkg::class_type cls;

   assign pos_inc = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};
   assign lim = (16'(payload_limit) > 16'(MAX_LEN)) ? 16'(MAX_LEN) : 16'(payload_limit);

   rfp_classify u_classify (
      .type_code (type_ff),
      .length    (len_ff),
      .head      (head_ff),
      .cls       (cls)
   );

   always_comb begin
      stage_in  = stage_ff;
      pos_in    = pos_ff;
      hxor_in   = hxor_ff;
      dxor_in   = dxor_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      head_in   = head_ff;
      res_valid = 1'b0;
      res.status          = rfp_pkg::STATUS_OK;
      res.seq_number      = seq_ff;
      res.frame_kind_code = type_ff;
      res.payload_length  = len_ff;
      res.kind            = rfp_pkg::KIND_OTHER;
      res.flag_bit        = 1'b0;
      res.payload_head    = head_ff;

      if (fire) begin
         if (cmd) begin
            if (stage_ff != rfp_pkg::STAGE_HUNT) begin
               res_valid  = 1'b1;
               res.status = rfp_pkg::STATUS_ABORT;
               if (stage_ff == rfp_pkg::STAGE_HEADER) begin
                  res.payload_head = 64'd0;
               end
               stage_in = rfp_pkg::STAGE_HUNT;
               pos_in   = '0;
            end
         end else begin
            case (stage_ff)
               rfp_pkg::STAGE_HUNT: begin
                  if (rx_byte == start_byte) begin
                     stage_in = rfp_pkg::STAGE_HEADER;
                     pos_in   = POS_W'(1);
                     hxor_in  = rx_byte;
                     seq_in   = 16'd0;
                     len_in   = 16'd0;
                     type_in  = 16'd0;
                     dxor_in  = 8'd0;
                     head_in  = 64'd0;
                  end
               end
               rfp_pkg::STAGE_HEADER: begin
                  if (pos_ff < POS_W'(rfp_pkg::HEADER_BYTES - 1)) begin
                     hxor_in = hxor_ff ^ rx_byte;
                     case (pos_ff[2:0])
                        3'd1:    seq_in[15:8]  = rx_byte;
                        3'd2:    seq_in[7:0]   = rx_byte;
                        3'd3:    len_in[15:8]  = rx_byte;
                        3'd4:    len_in[7:0]   = rx_byte;
                        3'd5:    type_in[15:8] = rx_byte;
                        default: type_in[7:0]  = rx_byte;
                     endcase
                     pos_in = pos_inc[POS_W-1:0];
                  end else if (~hxor_ff != rx_byte) begin
                     res_valid        = 1'b1;
                     res.status       = rfp_pkg::STATUS_HDR_BAD;
                     res.payload_head = 64'd0;
                     stage_in         = rfp_pkg::STAGE_HUNT;
                     pos_in           = '0;
                  end else if (len_ff > lim) begin
                     res_valid        = 1'b1;
                     res.status       = rfp_pkg::STATUS_TOO_LONG;
                     res.payload_head = 64'd0;
                     stage_in         = rfp_pkg::STAGE_HUNT;
                     pos_in           = '0;
                  end else begin
                     pos_in   = '0;
                     dxor_in  = 8'd0;
                     stage_in = (len_ff == 16'd0) ? rfp_pkg::STAGE_CHECK :
                                                    rfp_pkg::STAGE_PAYLOAD;
                  end
               end
               rfp_pkg::STAGE_PAYLOAD: begin
                  dxor_in = dxor_ff ^ rx_byte;
                  if (pos_ff < POS_W'(8)) begin
                     head_in[pos_ff[2:0]*8 +: 8] = rx_byte;
                  end
                  pos_in = pos_inc[POS_W-1:0];
                  if (16'(pos_inc) >= len_ff) begin
                     stage_in = rfp_pkg::STAGE_CHECK;
                  end
               end
               rfp_pkg::STAGE_CHECK: begin
                  res_valid = 1'b1;
                  stage_in  = rfp_pkg::STAGE_HUNT;
                  pos_in    = '0;
                  if (~dxor_ff != rx_byte) begin
                     res.status = rfp_pkg::STATUS_DATA_BAD;
                  end else begin
                     res.kind     = cls.kind;
                     res.flag_bit = cls.flag_bit;
                  end
               end
               default: begin
                  stage_in = rfp_pkg::STAGE_HUNT;
                  pos_in   = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= rfp_pkg::STAGE_HUNT;
         pos_ff   <= '0;
         hxor_ff  <= 8'd0;
         dxor_ff  <= 8'd0;
         seq_ff   <= 16'd0;
         len_ff   <= 16'd0;
         type_ff  <= 16'd0;
         head_ff  <= 64'd0;
      end else begin
         stage_ff <= stage_in;
         pos_ff   <= pos_in;
         hxor_ff  <= hxor_in;
         dxor_ff  <= dxor_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         head_ff  <= head_in;
      end
   end

   a_res_on_fire: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> fire)
      else $error("result without a transfer");

   a_res_to_hunt: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (stage_ff == rfp_pkg::STAGE_HUNT) && (pos_ff == '0))
      else $error("parser did not return to hunting after a result");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status != rfp_pkg::STATUS_OK)) |->
      ((res.kind == rfp_pkg::KIND_OTHER) && !res.flag_bit))
      else $error("failed frame carries a kind or flag");

   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == rfp_pkg::STAGE_HEADER) |->
      ((pos_ff != '0) && (pos_ff < POS_W'(rfp_pkg::HEADER_BYTES))))
      else $error("header position out of range");

endmodule

// File: rtl/core/rfp_out_reg.sv
// ---------------------------------------------------------------------------
// rfp_out_reg: result register
// Holds one result record until the downstream side takes it; reloads in
// the cycle it is drained.
// ---------------------------------------------------------------------------
module rfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rfp_pkg::result_type  load_data,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfp_pkg::result_type  out_data
);

   logic                valid_ff, valid_in;
   rfp_pkg::result_type data_ff, data_in;

   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register overwritten before transfer");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> (valid_ff && (data_ff == $past(load_data))))
      else $error("loaded result not presented");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ready && !load) |=> !valid_ff)
      else $error("drained result still held");

endmodule

// File: rtl/core/radar_frame_parser.sv
// ---------------------------------------------------------------------------
// radar_frame_parser: start-byte framed radar link parser
// Header and payload checksums, length limit, frame kind decode.
// ---------------------------------------------------------------------------
// One transfer per cycle: a byte or abort is taken in every cycle in which the
// result register is empty or being drained, so the rate is one item per
// clock. The result of the closing byte appears on rsp_ the following cycle.
// The frame state and captured fields are registered on each accepted byte; the
// only stall comes from a result that is not taken downstream.
// ---------------------------------------------------------------------------
module radar_frame_parser #(
   parameter int MAX_LEN = rfp_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [15:0]                       rsp_seq_number,
   output logic [15:0]                       rsp_frame_kind_code,
   output logic [15:0]                       rsp_payload_length,
   output logic [2:0]                        rsp_kind,
   output logic                              rsp_flag_bit,
   output logic [63:0]                       rsp_payload_head,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data
);

   logic [7:0]          start_ff;
   logic [6:0]          limit_ff;
   logic                fire;
   logic                res_valid;
   logic                free;
   rfp_pkg::result_type res;
   rfp_pkg::result_type out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= rfp_pkg::START_BYTE_RESET;
         limit_ff <= rfp_pkg::PAYLOAD_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rfp_pkg::CSR_START_BYTE:    start_ff <= csr_data;
            rfp_pkg::CSR_PAYLOAD_LIMIT: limit_ff <= csr_data[6:0];
            default: begin
               start_ff <= start_ff;
            end
         endcase
      end
   end

   assign req_ready = free;
   assign fire      = req_valid && req_ready;

   rfp_parser #(
      .MAX_LEN (MAX_LEN)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .cmd           (req_cmd),
      .rx_byte       (req_rx_byte),
      .start_byte    (start_ff),
      .payload_limit (limit_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   rfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .free      (free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_status          = out_data.status;
   assign rsp_seq_number      = out_data.seq_number;
   assign rsp_frame_kind_code = out_data.frame_kind_code;
   assign rsp_payload_length  = out_data.payload_length;
   assign rsp_kind            = out_data.kind;
   assign rsp_flag_bit        = out_data.flag_bit;
   assign rsp_payload_head    = out_data.payload_head;

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for radar_frame_parser
// Feeds framed byte streams (clean, corrupted, oversized, cut by abort
// commands) plus line noise, runs through several start byte and length limit
// settings, and checks every result record against an in-bench frame parser.
// Both handshakes see random idle and stall bursts except in the final phase.
// ---------------------------------------------------------------------------
module tb;

   localparam int PARSER_MAX_LEN = rfp_pkg::MAX_LEN_DEFAULT;

   typedef enum int {FLAW_NONE, FLAW_HDR, FLAW_DATA, FLAW_CUT_HDR, FLAW_CUT_BODY} flaw_type;

   class frame_checker;
      rfp_pkg::stage_type  stage;
      logic [6:0] pos;
      logic [7:0] hdr_xor;
      logic [7:0] body_xor;
      logic [15:0] seq;
      logic [15:0] len;
      logic [15:0] ftype;
      logic [63:0] head;
      logic [7:0] start_byte;
      logic [6:0] len_limit;
      int         max_len;
      int         errors;
      rfp_pkg::result_type frames_due[$];

      function new(int max_len_i);
         max_len = max_len_i;
         errors = 0;
         start_byte = rfp_pkg::START_BYTE_RESET;
         len_limit = rfp_pkg::PAYLOAD_LIMIT_RESET;
         stage = rfp_pkg::STAGE_HUNT;
         pos = '0;
         hdr_xor = '0;
         body_xor = '0;
         seq = '0;
         len = '0;
         ftype = '0;
         head = '0;
      endfunction

      function int eff_limit();
         return (int'(len_limit) < max_len) ? int'(len_limit) : max_len;
      endfunction

      function void set_reg(logic [rfp_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] d);
         case (idx)
            rfp_pkg::CSR_START_BYTE:    start_byte = d;
            rfp_pkg::CSR_PAYLOAD_LIMIT: len_limit = d[6:0];
            default: ;
         endcase
      endfunction

      function bit positive_float(logic [31:0] f);
         if (f[31] || f == 32'h0) return 1'b0;
         if (f[30:23] == 8'hFF && f[22:0] != 23'h0) return 1'b0;
         return 1'b1;
      endfunction

      function void push_result(logic [2:0] status, logic [2:0] kind, logic flag,
                                logic [63:0] head_v);
         rfp_pkg::result_type r;
         r.status = status;
         r.seq_number = seq;
         r.frame_kind_code = ftype;
         r.payload_length = len;
         r.kind = kind;
         r.flag_bit = flag;
         r.payload_head = head_v;
         frames_due.push_back(r);
         stage = rfp_pkg::STAGE_HUNT;
         pos = '0;
      endfunction

      function void take_input(logic cmd, logic [7:0] b);
         logic [2:0] kind;
         logic       flag;
         if (cmd) begin
            if (stage != rfp_pkg::STAGE_HUNT)
               push_result(rfp_pkg::STATUS_ABORT, rfp_pkg::KIND_OTHER, 1'b0,
                           (stage == rfp_pkg::STAGE_HEADER) ? 64'h0 : head);
            return;
         end
         case (stage)
            rfp_pkg::STAGE_HUNT: begin
               if (b == start_byte) begin
                  stage = rfp_pkg::STAGE_HEADER;
                  pos = 7'd1;
                  hdr_xor = b;
                  seq = '0;
                  len = '0;
                  ftype = '0;
                  body_xor = '0;
                  head = '0;
               end
            end
            rfp_pkg::STAGE_HEADER: begin
               if (int'(pos) < rfp_pkg::HEADER_BYTES - 1) begin
                  hdr_xor ^= b;
                  case (pos)
                     7'd1: seq[15:8] = b;
                     7'd2: seq[7:0] = b;
                     7'd3: len[15:8] = b;
                     7'd4: len[7:0] = b;
                     7'd5: ftype[15:8] = b;
                     default: ftype[7:0] = b;
                  endcase
                  pos = pos + 7'd1;
               end else if (~hdr_xor != b) begin
                  push_result(rfp_pkg::STATUS_HDR_BAD, rfp_pkg::KIND_OTHER, 1'b0, 64'h0);
               end else if (int'(len) > eff_limit()) begin
                  push_result(rfp_pkg::STATUS_TOO_LONG, rfp_pkg::KIND_OTHER, 1'b0, 64'h0);
               end else begin
                  pos = '0;
                  body_xor = '0;
                  stage = (len == 16'h0) ? rfp_pkg::STAGE_CHECK : rfp_pkg::STAGE_PAYLOAD;
               end
            end
            rfp_pkg::STAGE_PAYLOAD: begin
               body_xor ^= b;
               if (pos < 7'd8) head[int'(pos)*8 +: 8] = b;
               pos = pos + 7'd1;
               if ({9'd0, pos} >= len) stage = rfp_pkg::STAGE_CHECK;
            end
            default: begin
               if (~body_xor != b) begin
                  push_result(rfp_pkg::STATUS_DATA_BAD, rfp_pkg::KIND_OTHER, 1'b0, head);
               end else begin
                  kind = rfp_pkg::KIND_OTHER;
                  flag = 1'b0;
                  case (ftype)
                     rfp_pkg::CODE_BREATH:
                        kind = (len >= rfp_pkg::MIN_LEN_BREATH) ?
                               rfp_pkg::KIND_BREATH : rfp_pkg::KIND_SHORT;
                     rfp_pkg::CODE_HEART:
                        kind = (len >= rfp_pkg::MIN_LEN_HEART) ?
                               rfp_pkg::KIND_HEART : rfp_pkg::KIND_SHORT;
                     rfp_pkg::CODE_PHASE:
                        kind = (len >= rfp_pkg::MIN_LEN_PHASE) ?
                               rfp_pkg::KIND_PHASE : rfp_pkg::KIND_SHORT;
                     rfp_pkg::CODE_DISTANCE: begin
                        if (len >= rfp_pkg::MIN_LEN_DISTANCE) begin
                           kind = rfp_pkg::KIND_DISTANCE;
                           flag = (head[31:0] == rfp_pkg::DISTANCE_VALID_WORD) &&
                                  positive_float(head[63:32]);
                        end else begin
                           kind = rfp_pkg::KIND_SHORT;
                        end
                     end
                     rfp_pkg::CODE_HUMAN: begin
                        if (len >= rfp_pkg::MIN_LEN_HUMAN) begin
                           kind = rfp_pkg::KIND_HUMAN;
                           flag = (head[7:0] != 8'h0);
                        end else begin
                           kind = rfp_pkg::KIND_SHORT;
                        end
                     end
                     default: ;
                  endcase
                  push_result(rfp_pkg::STATUS_OK, kind, flag, head);
               end
            end
         endcase
      endfunction

      function void report_fault(string what, rfp_pkg::result_type want,
                                 rfp_pkg::result_type got);
         errors++;
         if (errors <= 10) begin
            $display("%s: exp st=%0d seq=%h typ=%h len=%h kind=%0d flag=%b head=%h",
                     what, want.status, want.seq_number, want.frame_kind_code,
                     want.payload_length, want.kind, want.flag_bit, want.payload_head);
            $display("%s: got st=%0d seq=%h typ=%h len=%h kind=%0d flag=%b head=%h",
                     what, got.status, got.seq_number, got.frame_kind_code,
                     got.payload_length, got.kind, got.flag_bit, got.payload_head);
         end
      endfunction

      function void check_result(rfp_pkg::result_type got);
         rfp_pkg::result_type want;
         if (frames_due.size() == 0) begin
            report_fault("unexpected result", '0, got);
            return;
         end
         want = frames_due.pop_front();
         if (got.status !== want.status || got.seq_number !== want.seq_number ||
             got.frame_kind_code !== want.frame_kind_code ||
             got.payload_length !== want.payload_length || got.kind !== want.kind ||
             got.flag_bit !== want.flag_bit || got.payload_head !== want.payload_head)
            report_fault("result mismatch", want, got);
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_cmd = 1'b0;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic [2:0]             rsp_status;
   logic [15:0]            rsp_seq_number;
   logic [15:0]            rsp_frame_kind_code;
   logic [15:0]            rsp_payload_length;
   logic [2:0]             rsp_kind;
   logic                   rsp_flag_bit;
   logic [63:0]            rsp_payload_head;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [rfp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data = 8'h00;

   frame_checker fc;
   int           frame_items;
   bit           quiet = 1'b0;

   radar_frame_parser #(.MAX_LEN(PARSER_MAX_LEN)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_seq_number(rsp_seq_number),
      .rsp_frame_kind_code(rsp_frame_kind_code),
      .rsp_payload_length(rsp_payload_length),
      .rsp_kind(rsp_kind),
      .rsp_flag_bit(rsp_flag_bit),
      .rsp_payload_head(rsp_payload_head),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side: random stall bursts and stall-free stretches
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 30) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         fc.check_result({rsp_status, rsp_seq_number, rsp_frame_kind_code,
                          rsp_payload_length, rsp_kind, rsp_flag_bit, rsp_payload_head});
   end

   // valid stays high across back-to-back transfers; lowered only for a gap
   task automatic send_item(input logic cmd, input logic [7:0] b, input bit gaps);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      fc.take_input(cmd, b);
      frame_items++;
      if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [15:0] seq, input logic [15:0] flen,
                             input logic [15:0] ftype, input logic [63:0] head,
                             input flaw_type flaw);
      logic [7:0] fb[$];
      logic [7:0] ck;
      int         cut;
      int         i;
      bit         gaps;
      gaps = ($urandom_range(0, 2) != 0);
      fb = {fc.start_byte, seq[15:8], seq[7:0], flen[15:8], flen[7:0],
            ftype[15:8], ftype[7:0]};
      ck = 8'h00;
      foreach (fb[j]) ck ^= fb[j];
      ck = ~ck;
      if (flaw == FLAW_HDR) ck ^= 8'($urandom_range(1, 255));
      fb.push_back(ck);
      if (flaw != FLAW_HDR && int'(flen) <= fc.eff_limit()) begin
         ck = 8'h00;
         for (i = 0; i < int'(flen); i++) begin
            fb.push_back((i < 8) ? head[i*8 +: 8] : 8'($urandom));
            ck ^= fb[fb.size()-1];
         end
         ck = ~ck;
         if (flaw == FLAW_DATA) ck ^= 8'($urandom_range(1, 255));
         fb.push_back(ck);
      end
      cut = fb.size();
      if (flaw == FLAW_CUT_HDR) cut = $urandom_range(1, 7);
      else if (flaw == FLAW_CUT_BODY) cut = $urandom_range(8, fb.size() - 1);
      for (i = 0; i < cut; i++) send_item(1'b0, fb[i], gaps);
      if (flaw == FLAW_CUT_HDR || flaw == FLAW_CUT_BODY)
         send_item(1'b1, 8'($urandom), gaps);
   endtask

   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom);
         if (b == fc.start_byte && $urandom_range(0, 3) != 0) b ^= 8'h01;
         send_item($urandom_range(0, 4) == 0, b, 1'b1);
      end
   endtask

   task automatic rand_frame();
      logic [15:0] ftype;
      logic [15:0] flen;
      logic [63:0] head;
      flaw_type    flaw;
      int          lim;
      int          r;
      lim = fc.eff_limit();
      case ($urandom_range(0, 6))
         0: ftype = rfp_pkg::CODE_BREATH;
         1: ftype = rfp_pkg::CODE_HEART;
         2: ftype = rfp_pkg::CODE_DISTANCE;
         3: ftype = rfp_pkg::CODE_HUMAN;
         4: ftype = rfp_pkg::CODE_PHASE;
         default: ftype = 16'($urandom);
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) flen = 16'($urandom);
      else if (r == 1) flen = 16'(lim + $urandom_range(1, 3));
      else if (r == 2) flen = 16'(lim);
      else flen = 16'($urandom_range(0, (lim < 16) ? lim : 16));
      head = {$urandom, $urandom};
      if (ftype == rfp_pkg::CODE_DISTANCE && $urandom_range(0, 1) == 0) begin
         head[31:0] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 2)) :
                      rfp_pkg::DISTANCE_VALID_WORD;
         case ($urandom_range(0, 8))
            0: head[63:32] = 32'h0000_0000;
            1: head[63:32] = 32'h8000_0000;
            2: head[63:32] = 32'hBF80_0000;
            3: head[63:32] = 32'h7FC0_0000;
            4: head[63:32] = 32'h7F80_0001;
            5: head[63:32] = 32'h0000_0001;
            6: head[63:32] = 32'h7F80_0000;
            7: head[63:32] = 32'h3F80_0000;
            default: ;
         endcase
      end
      if (ftype == rfp_pkg::CODE_HUMAN && $urandom_range(0, 2) == 0) head[7:0] = 8'h00;
      case ($urandom_range(0, 19))
         0, 1: flaw = FLAW_HDR;
         2, 3: flaw = FLAW_DATA;
         4: flaw = FLAW_CUT_HDR;
         5: flaw = FLAW_CUT_BODY;
         default: flaw = FLAW_NONE;
      endcase
      send_frame(16'($urandom), flen, ftype, head, flaw);
   endtask

   task automatic run_random(input int n_items);
      frame_items = 0;
      while (frame_items < n_items) begin
         if (fc.stage != rfp_pkg::STAGE_HUNT) send_item(1'b1, 8'($urandom), 1'b1);
         send_noise();
         rand_frame();
      end
   endtask

   task automatic write_reg(input logic [rfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      fc.set_reg(idx, d);
   endtask

   // close any open frame and let the parser drain before touching registers
   task automatic settle();
      if (fc.stage != rfp_pkg::STAGE_HUNT) send_item(1'b1, 8'($urandom), 1'b0);
      req_valid <= 1'b0;
      while (fc.frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] start_b, input logic [7:0] limit,
                            input int n_items);
      settle();
      write_reg(rfp_pkg::CSR_START_BYTE, start_b);
      write_reg(rfp_pkg::CSR_PAYLOAD_LIMIT, limit);
      csr_valid <= 1'b0;
      run_random(n_items);
   endtask

   initial begin
      fc = new(PARSER_MAX_LEN);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(1'b1, 8'hFF, 1'b1);
      send_frame(16'hFFFF, 16'd0, 16'h0000, 64'h0, FLAW_NONE);
      send_frame(16'h0000, 16'd1, rfp_pkg::CODE_HUMAN, 64'h0, FLAW_NONE);
      send_frame(16'h1234, 16'd1, rfp_pkg::CODE_HUMAN, 64'hFF, FLAW_NONE);
      send_frame(16'h8001, 16'd4, rfp_pkg::CODE_DISTANCE, 64'h0, FLAW_NONE);
      send_frame(16'h7FFE, 16'd8, rfp_pkg::CODE_DISTANCE, 64'h3F80_0000_0000_0001,
                 FLAW_NONE);
      send_frame(16'h5555, 16'd0, rfp_pkg::CODE_PHASE, 64'h0, FLAW_HDR);
      send_frame(16'hAAAA, 16'hFFFF, rfp_pkg::CODE_BREATH, 64'h0, FLAW_NONE);
      send_frame(16'h0101, 16'd65, rfp_pkg::CODE_HEART, 64'h0, FLAW_NONE);
      send_frame(16'h0F0F, 16'd3, rfp_pkg::CODE_HEART, 64'hFFFF_FFFF_FFFF_FFFF,
                 FLAW_DATA);
      send_frame(16'hF0F0, 16'd5, rfp_pkg::CODE_BREATH, 64'h0, FLAW_CUT_HDR);
      send_frame(16'h3C3C, 16'd6, rfp_pkg::CODE_BREATH, 64'h0, FLAW_CUT_BODY);
      run_random(80);

      run_phase(8'hFF, 8'h7F, 150);
      run_phase(8'h00, 8'h00, 100);
      run_phase(8'hAA, 8'h0C, 150);
      run_phase(8'($urandom), 8'hC8, 150);
      run_phase(8'($urandom), 8'($urandom_range(0, 127)), 100);
      quiet = 1'b1;
      run_phase(8'h55, 8'd64, 150);

      settle();
      repeat (10) @(posedge clock);
      if (fc.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
